FILE: hw/rtl/esc_pkg.sv
package esc_pkg;

    // divider word width and sideband width carried alongside it
    localparam int DIV_W  = 32;
    localparam int SIDE_W = 32 + 17 + 1 + 1;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_CAL_TEMP     = 3'd0,
        REG_CAL_PRESS_A  = 3'd1,
        REG_CAL_PRESS_B  = 3'd2,
        REG_CAL_PRESS_P9 = 3'd3,
        REG_CAL_HUMID_A  = 3'd4,
        REG_CAL_HUMID_H6 = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] quo;
    } div_state_t;

    // arithmetic right shift of a 32-bit pattern
    function automatic logic [31:0] asr(logic [31:0] x, logic [4:0] s);
        asr = 32'($signed(x) >>> s);
    endfunction

    function automatic logic [31:0] sx16(logic [15:0] x);
        sx16 = {{16{x[15]}}, x};
    endfunction

    function automatic logic [31:0] sx8(logic [7:0] x);
        sx8 = {{24{x[7]}}, x};
    endfunction

    // one restoring division step: shift in the next dividend bit, subtract if it fits
    function automatic div_state_t div_step(div_state_t st, logic [DIV_W-1:0] den);
        logic [DIV_W:0] trial;
        div_state_t     nx;
        trial = {st.rem, st.quo[DIV_W-1]};
        if (trial >= {1'b0, den}) begin
            nx.rem = DIV_W'(trial - {1'b0, den});
            nx.quo = {st.quo[DIV_W-2:0], 1'b1};
        end else begin
            nx.rem = trial[DIV_W-1:0];
            nx.quo = {st.quo[DIV_W-2:0], 1'b0};
        end
        div_step = nx;
    endfunction

endpackage

FILE: hw/rtl/esc_divider.sv
module esc_divider #(
    parameter int SW = esc_pkg::SIDE_W
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [esc_pkg::DIV_W-1:0] num,
    input  logic [esc_pkg::DIV_W-1:0] den,
    input  logic [SW-1:0]            side_in,
    output logic                     out_valid,
    output logic [esc_pkg::DIV_W-1:0] quot,
    output logic [SW-1:0]            side_out
);
    import esc_pkg::*;

    localparam int W = DIV_W;

    div_state_t     st_reg   [0:W-1];
    logic [W-1:0]   den_reg  [0:W-1];
    logic [SW-1:0]  side_reg [0:W-1];
    logic [W-1:0]   vld_reg;

    // one quotient bit per stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[W-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0]   <= div_step('{rem: '0, quo: num}, den);
            den_reg[0]  <= den;
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 1; k < W; k++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[k]   <= div_step(st_reg[k-1], den_reg[k-1]);
                den_reg[k]  <= den_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[W-1];
    assign quot      = st_reg[W-1].quo;
    assign side_out  = side_reg[W-1];

endmodule

FILE: hw/rtl/env_sensor_compensation.sv
// channel   | direction | content
// s_*       | in        | raw temperature, pressure, humidity set (stream)
// m_*       | out       | compensated temperature, pressure, humidity, invalid flag
// p*        | in/out    | calibration registers, 64-bit, byte address 8*index
//
// one transaction per cycle sustained while the output is not stalled; from accept to m_tvalid:
// 12 arithmetic stages, a 32-stage restoring divider (one quotient bit per stage)
// and 3 pressure correction stages ending in the output register
// aresetn is synchronous active low and clears the valid bits and calibration registers
// the whole pipeline advances together; it holds when the output register is
// full and not taken, so s_tready drops in that cycle
module env_sensor_compensation (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // raw_temperature [19:0], raw_pressure [39:20], raw_humidity [55:40]
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // temperature_centi [31:0], pressure_pa [63:32], humidity_q10 [80:64], zero pad
    output logic [87:0] m_tdata,
    // pressure_invalid [0]
    output logic [0:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import esc_pkg::*;

    localparam logic [31:0] C_64000    = 32'd64000;
    localparam logic [31:0] C_1M       = 32'd1048576;
    localparam logic [31:0] C_3125     = 32'd3125;
    localparam logic [31:0] C_76800    = 32'd76800;
    localparam logic [31:0] C_2M       = 32'd2097152;
    localparam logic [31:0] C_HUM_MAX  = 32'd419430400;
    localparam logic [31:0] C_16384    = 32'd16384;
    localparam logic [31:0] C_32768    = 32'd32768;
    localparam logic [31:0] C_8192     = 32'd8192;
    localparam logic [31:0] C_128      = 32'd128;

    // ---------------------------------------------------------------- config
    logic [47:0] cal_temp_reg;
    logic [63:0] cal_press_a_reg;
    logic [63:0] cal_press_b_reg;
    logic [15:0] cal_press_p9_reg;
    logic [63:0] cal_humid_a_reg;
    logic [7:0]  cal_humid_h6_reg;
    logic        wr_en;
    reg_idx_t    wr_idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign wr_idx = reg_idx_t'(paddr[5:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_temp_reg     <= '0;
            cal_press_a_reg  <= '0;
            cal_press_b_reg  <= '0;
            cal_press_p9_reg <= '0;
            cal_humid_a_reg  <= '0;
            cal_humid_h6_reg <= '0;
        end else if (wr_en) begin
            // index six and seven are unmapped, writes there are dropped
            case (wr_idx)
                REG_CAL_TEMP:     cal_temp_reg     <= pwdata[47:0];
                REG_CAL_PRESS_A:  cal_press_a_reg  <= pwdata;
                REG_CAL_PRESS_B:  cal_press_b_reg  <= pwdata;
                REG_CAL_PRESS_P9: cal_press_p9_reg <= pwdata[15:0];
                REG_CAL_HUMID_A:  cal_humid_a_reg  <= pwdata;
                REG_CAL_HUMID_H6: cal_humid_h6_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (wr_idx)
            REG_CAL_TEMP:     prdata = {16'd0, cal_temp_reg};
            REG_CAL_PRESS_A:  prdata = cal_press_a_reg;
            REG_CAL_PRESS_B:  prdata = cal_press_b_reg;
            REG_CAL_PRESS_P9: prdata = {48'd0, cal_press_p9_reg};
            REG_CAL_HUMID_A:  prdata = cal_humid_a_reg;
            REG_CAL_HUMID_H6: prdata = {56'd0, cal_humid_h6_reg};
            default:          prdata = '0;
        endcase
    end

    // coefficient fields, extended to 32 bits (t1, p1, h1, h3 zero extended, the rest sign extended)
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;

    assign t1 = {16'd0, cal_temp_reg[15:0]};
    assign t2 = sx16(cal_temp_reg[31:16]);
    assign t3 = sx16(cal_temp_reg[47:32]);
    assign p1 = {16'd0, cal_press_a_reg[15:0]};
    assign p2 = sx16(cal_press_a_reg[31:16]);
    assign p3 = sx16(cal_press_a_reg[47:32]);
    assign p4 = sx16(cal_press_a_reg[63:48]);
    assign p5 = sx16(cal_press_b_reg[15:0]);
    assign p6 = sx16(cal_press_b_reg[31:16]);
    assign p7 = sx16(cal_press_b_reg[47:32]);
    assign p8 = sx16(cal_press_b_reg[63:48]);
    assign p9 = sx16(cal_press_p9_reg);
    assign h1 = {24'd0, cal_humid_a_reg[7:0]};
    assign h3 = {24'd0, cal_humid_a_reg[15:8]};
    assign h2 = sx16(cal_humid_a_reg[31:16]);
    assign h4 = sx16(cal_humid_a_reg[47:32]);
    assign h5 = sx16(cal_humid_a_reg[63:48]);
    assign h6 = sx8(cal_humid_h6_reg);

    // ---------------------------------------------------------------- flow
    // single advance enable for every stage; output register frees the pipe
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    logic [12:1] v_reg;   // valid bits of the front stages
    logic [2:1]  pv_reg;  // valid bits of the pressure correction stages
    logic        out_v_reg;

    logic [19:0] adc_t, adc_p;
    logic [15:0] adc_h;
    logic [31:0] td;
    assign adc_t = s_tdata[19:0];
    assign adc_p = s_tdata[39:20];
    assign adc_h = s_tdata[55:40];
    assign td    = {16'd0, adc_t[19:4]} - t1;

    // stage payload registers
    logic [31:0] ta1_reg, tdd1_reg;
    logic [19:0] adcp_reg [1:7];
    logic [15:0] adch_reg [1:5];
    logic [31:0] ta2_reg, tb2_reg;
    logic [31:0] fine3_reg;
    logic [31:0] temp_reg [4:12];
    logic [31:0] pa4_reg, hv4_reg;
    logic [31:0] q5_reg, ap5_reg, p2a5_reg, hv5_reg, vh6_5_reg, vh3_5_reg;
    logic [31:0] b1_6_reg, ap6_reg, p3q6_reg, p2a6_reg, hx6_reg, hy6_reg;
    logic [31:0] huma_reg [6:8];
    logic [31:0] pb7_reg, pa7_reg, hb7_reg;
    logic [31:0] a2m8_reg, hb8_reg, pp8_reg;
    logic [31:0] den_reg  [9:12];
    logic [31:0] num_reg  [9:12];
    logic        post_reg [9:12];
    logic [31:0] hv9_reg, hv10_reg, hv11_reg;
    logic [31:0] qh10_reg, mh11_reg;
    logic [16:0] hum12_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[11:1], s_tvalid};
        end
    end

    logic [31:0] fine5;
    logic [31:0] hum_raw_a;
    logic [31:0] pp_sub;
    logic [31:0] hv_fin;
    assign fine5     = {fine3_reg[29:0], 2'b00} + fine3_reg;
    assign hum_raw_a = {2'd0, adch_reg[5], 14'd0} - {h4[11:0], 20'd0} - hv5_reg + C_16384;
    assign pp_sub    = (C_1M - {12'd0, adcp_reg[7]}) - asr(pb7_reg, 5'd12);
    assign hv_fin    = hv11_reg - asr(mh11_reg, 5'd4);

    always_ff @(posedge aclk) begin
        if (en) begin
            // temperature
            ta1_reg  <= ({15'd0, adc_t[19:3]} - {t1[30:0], 1'b0}) * t2;
            tdd1_reg <= td * td;
            adcp_reg[1] <= adc_p;
            adch_reg[1] <= adc_h;
            for (int k = 2; k <= 7; k++) adcp_reg[k] <= adcp_reg[k-1];
            for (int k = 2; k <= 5; k++) adch_reg[k] <= adch_reg[k-1];

            ta2_reg   <= asr(ta1_reg, 5'd11);
            tb2_reg   <= asr(tdd1_reg, 5'd12) * t3;
            fine3_reg <= ta2_reg + asr(tb2_reg, 5'd14);

            temp_reg[4] <= asr(fine5 + C_128, 5'd8);
            for (int k = 5; k <= 12; k++) temp_reg[k] <= temp_reg[k-1];
            pa4_reg <= asr(fine3_reg, 5'd1) - C_64000;
            hv4_reg <= fine3_reg - C_76800;

            // products of the fine temperature terms
            q5_reg    <= asr(pa4_reg, 5'd2) * asr(pa4_reg, 5'd2);
            ap5_reg   <= pa4_reg * p5;
            p2a5_reg  <= p2 * pa4_reg;
            hv5_reg   <= h5 * hv4_reg;
            vh6_5_reg <= hv4_reg * h6;
            vh3_5_reg <= hv4_reg * h3;

            b1_6_reg    <= asr(q5_reg, 5'd11) * p6;
            ap6_reg     <= ap5_reg;
            p3q6_reg    <= p3 * asr(q5_reg, 5'd13);
            p2a6_reg    <= p2a5_reg;
            huma_reg[6] <= asr(hum_raw_a, 5'd15);
            hx6_reg     <= asr(vh6_5_reg, 5'd10);
            hy6_reg     <= asr(vh3_5_reg, 5'd11) + C_32768;

            pb7_reg <= asr(b1_6_reg + {ap6_reg[30:0], 1'b0}, 5'd2) + {p4[15:0], 16'd0};
            pa7_reg <= asr(asr(p3q6_reg, 5'd3) + asr(p2a6_reg, 5'd1), 5'd18);
            hb7_reg <= hx6_reg * hy6_reg;
            huma_reg[7] <= huma_reg[6];

            a2m8_reg <= (C_32768 + pa7_reg) * p1;
            hb8_reg  <= (asr(hb7_reg, 5'd10) + C_2M) * h2 + C_8192;
            pp8_reg  <= pp_sub * C_3125;
            huma_reg[8] <= huma_reg[7];

            // divider operands; top bit of the dividend picks the branch
            den_reg[9]  <= asr(a2m8_reg, 5'd15);
            num_reg[9]  <= pp8_reg[31] ? pp8_reg : {pp8_reg[30:0], 1'b0};
            post_reg[9] <= pp8_reg[31];
            hv9_reg     <= huma_reg[8] * asr(hb8_reg, 5'd14);
            for (int k = 10; k <= 12; k++) begin
                den_reg[k]  <= den_reg[k-1];
                num_reg[k]  <= num_reg[k-1];
                post_reg[k] <= post_reg[k-1];
            end

            qh10_reg <= asr(hv9_reg, 5'd15) * asr(hv9_reg, 5'd15);
            hv10_reg <= hv9_reg;
            mh11_reg <= asr(qh10_reg, 5'd7) * h1;
            hv11_reg <= hv10_reg;

            // humidity clamp to 0..100 %RH
            if (hv_fin[31]) begin
                hum12_reg <= '0;
            end else if (hv_fin > C_HUM_MAX) begin
                hum12_reg <= C_HUM_MAX[28:12];
            end else begin
                hum12_reg <= hv_fin[28:12];
            end
        end
    end

    // ---------------------------------------------------------------- divider
    logic              dv_valid;
    logic [31:0]       dv_quot;
    logic [SIDE_W-1:0] dv_side_in, dv_side;

    // side: temperature, humidity, invalid flag, doubling flag
    assign dv_side_in = {temp_reg[12], hum12_reg, (den_reg[12] == 32'd0), post_reg[12]};

    esc_divider #(.SW(SIDE_W)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v_reg[12]),
        .num       (num_reg[12]),
        .den       (den_reg[12]),
        .side_in   (dv_side_in),
        .out_valid (dv_valid),
        .quot      (dv_quot),
        .side_out  (dv_side)
    );

    // ---------------------------------------------------------------- pressure tail
    logic [31:0] pq;
    assign pq = dv_side[0] ? {dv_quot[30:0], 1'b0} : dv_quot;

    logic [31:0] p1_reg, ps1_reg, pb1_reg, p2_reg, pa9_2_reg, pb2_reg;
    logic [SIDE_W-1:1] side_reg [1:2];
    logic [31:0] p_fin;
    logic [31:0] out_temp_reg, out_press_reg;
    logic [16:0] out_hum_reg;
    logic        out_inv_reg;

    assign p_fin = p2_reg + asr(asr(pa9_2_reg, 5'd12) + asr(pb2_reg, 5'd13) + p7, 5'd4);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg    <= '0;
            out_v_reg <= 1'b0;
        end else if (en) begin
            pv_reg    <= {pv_reg[1], dv_valid};
            out_v_reg <= pv_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg      <= pq;
            ps1_reg     <= {3'd0, pq[31:3]} * {3'd0, pq[31:3]};
            pb1_reg     <= {2'd0, pq[31:2]} * p8;
            side_reg[1] <= dv_side[SIDE_W-1:1];

            p2_reg      <= p1_reg;
            pa9_2_reg   <= p9 * {13'd0, ps1_reg[31:13]};
            pb2_reg     <= pb1_reg;
            side_reg[2] <= side_reg[1];

            // zero divisor forces pressure to zero
            out_temp_reg  <= side_reg[2][SIDE_W-1:19];
            out_hum_reg   <= side_reg[2][18:2];
            out_inv_reg   <= side_reg[2][1];
            out_press_reg <= side_reg[2][1] ? 32'd0 : p_fin;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {7'd0, out_hum_reg, out_press_reg, out_temp_reg};
    assign m_tuser  = out_inv_reg;

    // ---------------------------------------------------------------- checks
    a_inv_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[63:32] == 32'd0)
        else $error("invalid pressure not forced to zero");

    a_hum_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[80:64] <= 17'd102400)
        else $error("humidity beyond clamp");

    a_ready : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while pipeline stalled");

endmodule

FILE: bench/env_sensor_compensation_test.sv
`timescale 1ns / 100ps

module env_sensor_compensation_test;
    import esc_pkg::*;

    localparam int PIPE_LATENCY = 47;
    localparam int RANDOM_SETS  = 1000;

    typedef struct packed {
        logic [31:0] temperature_centi;
        logic [31:0] pressure_pa;
        logic [16:0] humidity_q10;
        logic        pressure_invalid;
    } comp_result_t;

    // one directed row: raw set, and an optional typed-in expectation
    typedef struct {
        logic [19:0]  raw_t;
        logic [19:0]  raw_p;
        logic [15:0]  raw_h;
        bit           fixed;
        comp_result_t want;
    } raw_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    // calibration copy held by the bench
    logic [47:0] cal_t;
    logic [63:0] cal_pa;
    logic [63:0] cal_pb;
    logic [15:0] cal_p9;
    logic [63:0] cal_ha;
    logic [7:0]  cal_h6;

    comp_result_t pending_results[$];
    int           error_count;
    bit           drain_mode; // long stretch with no idling on either side

    env_sensor_compensation DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock, 10 ns period
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // arithmetic shift of a 32-bit pattern
    function automatic logic [31:0] sra32(logic [31:0] x, int s);
        return $signed(x) >>> s;
    endfunction

    // compensation of one raw set under the current calibration
    function automatic comp_result_t compensate(logic [19:0] adc_t, logic [19:0] adc_p,
                                                logic [15:0] adc_h);
        logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] h1, h2, h3, h4, h5, h6;
        logic [31:0] a, b, d, q, fine, p, v;
        comp_result_t r;
        t1 = {16'd0, cal_t[15:0]};
        t2 = {{16{cal_t[31]}}, cal_t[31:16]};
        t3 = {{16{cal_t[47]}}, cal_t[47:32]};
        p1 = {16'd0, cal_pa[15:0]};
        p2 = {{16{cal_pa[31]}}, cal_pa[31:16]};
        p3 = {{16{cal_pa[47]}}, cal_pa[47:32]};
        p4 = {{16{cal_pa[63]}}, cal_pa[63:48]};
        p5 = {{16{cal_pb[15]}}, cal_pb[15:0]};
        p6 = {{16{cal_pb[31]}}, cal_pb[31:16]};
        p7 = {{16{cal_pb[47]}}, cal_pb[47:32]};
        p8 = {{16{cal_pb[63]}}, cal_pb[63:48]};
        p9 = {{16{cal_p9[15]}}, cal_p9};
        h1 = {24'd0, cal_ha[7:0]};
        h3 = {24'd0, cal_ha[15:8]};
        h2 = {{16{cal_ha[31]}}, cal_ha[31:16]};
        h4 = {{16{cal_ha[47]}}, cal_ha[47:32]};
        h5 = {{16{cal_ha[63]}}, cal_ha[63:48]};
        h6 = {{24{cal_h6[7]}}, cal_h6};

        // fine temperature and centi-degrees
        a = sra32(((32'(adc_t) >> 3) - (t1 << 1)) * t2, 11);
        d = (32'(adc_t) >> 4) - t1;
        b = sra32(sra32(d * d, 12) * t3, 14);
        fine = a + b;
        r.temperature_centi = sra32(fine * 32'd5 + 32'd128, 8);

        // pressure, divisor zero gives the invalid flag
        a = sra32(fine, 1) - 32'd64000;
        q = sra32(a, 2) * sra32(a, 2);
        b = sra32(q, 11) * p6;
        b = b + ((a * p5) << 1);
        b = sra32(b, 2) + (p4 << 16);
        a = sra32(sra32(p3 * sra32(q, 13), 3) + sra32(p2 * a, 1), 18);
        a = sra32((32'd32768 + a) * p1, 15);
        if (a == 32'd0) begin
            p = 32'd0;
            r.pressure_invalid = 1'b1;
        end else begin
            r.pressure_invalid = 1'b0;
            p = ((32'd1048576 - 32'(adc_p)) - sra32(b, 12)) * 32'd3125;
            if (p < 32'h8000_0000) begin
                p = (p << 1) / a;
            end else begin
                p = (p / a) * 32'd2;
            end
            a = sra32(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
            b = sra32((p >> 2) * p8, 13);
            p = p + sra32(a + b + p7, 4);
        end
        r.pressure_pa = p;

        // humidity, clamped to 0..100 %RH
        v = fine - 32'd76800;
        a = sra32(((32'(adc_h) << 14) - (h4 << 20) - (h5 * v)) + 32'd16384, 15);
        b = sra32(v * h6, 10) * (sra32(v * h3, 11) + 32'd32768);
        b = (sra32(b, 10) + 32'd2097152) * h2 + 32'd8192;
        v = a * sra32(b, 14);
        q = sra32(v, 15) * sra32(v, 15);
        v = v - sra32(sra32(q, 7) * h1, 4);
        if (v[31]) begin
            v = 32'd0;
        end
        if (v > 32'd419430400) begin
            v = 32'd419430400;
        end
        r.humidity_q10 = v[28:12];
        return r;
    endfunction

    // apb write, setup then access cycle
    task automatic write_cal(reg_idx_t idx, logic [63:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 6'(idx) << 3;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CAL_TEMP:     cal_t  = value[47:0];
            REG_CAL_PRESS_A:  cal_pa = value;
            REG_CAL_PRESS_B:  cal_pb = value;
            REG_CAL_PRESS_P9: cal_p9 = value[15:0];
            REG_CAL_HUMID_A:  cal_ha = value;
            REG_CAL_HUMID_H6: cal_h6 = value[7:0];
            default: ;
        endcase
    endtask

    task automatic write_all_cal(logic [47:0] t, logic [63:0] pa, logic [63:0] pb,
                                 logic [15:0] p9, logic [63:0] ha, logic [7:0] h6);
        write_cal(REG_CAL_TEMP, {16'd0, t});
        write_cal(REG_CAL_PRESS_A, pa);
        write_cal(REG_CAL_PRESS_B, pb);
        write_cal(REG_CAL_PRESS_P9, {48'd0, p9});
        write_cal(REG_CAL_HUMID_A, ha);
        write_cal(REG_CAL_HUMID_H6, {56'd0, h6});
    endtask

    // one raw set transaction; valid idles at random unless draining
    task automatic send_raw(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh,
                            bit fixed, comp_result_t want);
        comp_result_t exp_r;
        while (!drain_mode && $urandom_range(99) < 34) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rh, rp, rt};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        exp_r = compensate(rt, rp, rh);
        if (fixed && exp_r != want) begin
            // typed-in value disagrees with the predictor: bench table error
            $error("directed row mismatch, table %h predictor %h", want, exp_r);
            error_count++;
        end
        pending_results.push_back(fixed ? want : exp_r);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(negedge aclk);
        end
        repeat (PIPE_LATENCY + 5) @(negedge aclk);
    endtask

    // result side: random stalls, compare at the rising edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= drain_mode || ($urandom_range(99) >= 34);
        end
    end

    always @(posedge aclk) begin
        comp_result_t got, exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got.temperature_centi = m_tdata[31:0];
            got.pressure_pa       = m_tdata[63:32];
            got.humidity_q10      = m_tdata[80:64];
            got.pressure_invalid  = m_tuser[0];
            if (pending_results.size() == 0) begin
                $error("result transaction with nothing expected");
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (got.temperature_centi != exp_r.temperature_centi) begin
                    $error("temperature_centi expected %0d actual %0d",
                           $signed(exp_r.temperature_centi), $signed(got.temperature_centi));
                    error_count++;
                end
                if (got.pressure_pa != exp_r.pressure_pa) begin
                    $error("pressure_pa expected %0d actual %0d",
                           exp_r.pressure_pa, got.pressure_pa);
                    error_count++;
                end
                if (got.humidity_q10 != exp_r.humidity_q10) begin
                    $error("humidity_q10 expected %0d actual %0d",
                           exp_r.humidity_q10, got.humidity_q10);
                    error_count++;
                end
                if (got.pressure_invalid != exp_r.pressure_invalid) begin
                    $error("pressure_invalid expected %0d actual %0d",
                           exp_r.pressure_invalid, got.pressure_invalid);
                    error_count++;
                end
            end
        end
    end

    // realistic calibration neighborhood so the divider branch is exercised
    task automatic write_typical_cal();
        write_all_cal({16'($urandom_range(65535)), 16'($urandom_range(30000, 24000)),
                       16'($urandom_range(65535))},
                      {16'($urandom_range(65535)), 16'($urandom_range(65535)),
                       16'($urandom_range(65535)), 16'($urandom_range(40000, 30000))},
                      {$urandom, $urandom},
                      16'($urandom),
                      {$urandom, $urandom},
                      8'($urandom));
    endtask

    initial begin
        raw_row_t    rows[$];
        raw_row_t    row;
        comp_result_t zero_res;
        int          phase;

        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        drain_mode = 1'b0;
        error_count = 0;
        cal_t = '0; cal_pa = '0; cal_pb = '0; cal_p9 = '0; cal_ha = '0; cal_h6 = '0;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // all-zero calibration after reset: temperature 0, divisor zero, humidity 0
        zero_res = '{temperature_centi: 32'd0, pressure_pa: 32'd0,
                     humidity_q10: 17'd0, pressure_invalid: 1'b1};
        rows.push_back('{20'd0, 20'd0, 16'd0, 1'b1, zero_res});
        rows.push_back('{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b0, zero_res});
        rows.push_back('{20'h80000, 20'h7FFFF, 16'h8000, 1'b0, zero_res});
        foreach (rows[i]) begin
            send_raw(rows[i].raw_t, rows[i].raw_p, rows[i].raw_h, rows[i].fixed,
                     rows[i].want);
        end
        wait_drained();

        // directed: extremes of every coefficient and raw field, then a typical calibration
        rows.delete();
        row.fixed = 1'b0;
        row.want  = zero_res;
        for (int i = 0; i < 6; i++) begin
            row.raw_t = (i % 2) ? 20'hFFFFF : 20'd0;
            row.raw_p = (i % 3 == 0) ? 20'd0 : 20'hFFFFF;
            row.raw_h = (i < 3) ? 16'hFFFF : 16'd0;
            rows.push_back(row);
        end
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: write_all_cal('1, '1, '1, '1, '1, '1);
                1: write_all_cal({16'h8000, 16'h8000, 16'hFFFF},
                                 {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF},
                                 {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF},
                                 16'h8000, {16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF}, 8'h80);
                default: write_all_cal({16'd50, 16'd26000, 16'd27000},
                                       {16'd8000, 16'd1, 16'hD600, 16'd36000},
                                       {16'hFFF9, 16'd9900, 16'hD120, 16'd140},
                                       16'd6000, {16'd320, 16'd370, 16'd0, 16'h4B},
                                       8'd30);
            endcase
            foreach (rows[i]) begin
                send_raw(rows[i].raw_t, rows[i].raw_p, rows[i].raw_h, 1'b0, zero_res);
            end
            wait_drained();
        end

        // random part over several calibration settings
        for (phase = 0; phase < 5; phase++) begin
            if (phase == 4) begin
                write_all_cal(48'({$urandom, $urandom}), {$urandom, $urandom},
                              {$urandom, $urandom}, 16'($urandom),
                              {$urandom, $urandom}, 8'($urandom));
            end else begin
                write_typical_cal();
            end
            drain_mode = (phase == 2);
            for (int n = 0; n < RANDOM_SETS / 5; n++) begin
                send_raw(20'($urandom), 20'($urandom), 16'($urandom), 1'b0, zero_res);
            end
            drain_mode = 1'b0;
            wait_drained();
        end

        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

endmodule
